// ===== sv/pes_pkg.sv =====
package pes_pkg;

  localparam logic [1:0] MODE_GENERIC = 2'd0;
  localparam logic [1:0] MODE_PATH    = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_word_t;

  // A classified word: esc set means the byte goes out as a percent sign and two hex digits.
  typedef struct packed {
    logic       esc;
    logic [7:0] data;
    logic       last;
  } cls_word_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage

// ===== sv/pes_front.sv =====
module pes_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               in_push,
  input  pes_pkg::in_word_t  in_word,
  output logic               q_push,
  output pes_pkg::cls_word_t q_word
);
  import pes_pkg::*;

  logic [1:0] mode_r;
  logic       alnum;
  logic       pass;
  logic [7:0] b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GENERIC;
    end else if (cfg_we) begin
      mode_r <= cfg_data;
    end
  end

  assign b = in_word.in_byte;

  always_comb begin
    alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
            (b >= 8'h61 && b <= 8'h7a);
    pass  = alnum || b == 8'h2d || b == 8'h2e || b == 8'h5f || b == 8'h7e ||
            ((mode_r == MODE_PATH || mode_r == MODE_QUERY) && b == 8'h2f) ||
            (mode_r == MODE_QUERY && b == 8'h3d);
    q_word.last = in_word.in_last;
    if (pass) begin
      q_word.esc  = 1'b0;
      q_word.data = b;
    end else if (mode_r == MODE_QUERY && b == CHAR_SPACE) begin
      q_word.esc  = 1'b0;
      q_word.data = CHAR_PLUS;
    end else begin
      q_word.esc  = 1'b1;
      q_word.data = b;
    end
  end

  assign q_push = in_push;

endmodule

// ===== sv/pes_queue.sv =====
module pes_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pes_pkg::cls_word_t push_word,
  output logic               full,
  input  logic               pop,
  output pes_pkg::cls_word_t pop_word,
  output logic               empty
);
  import pes_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cls_word_t         mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== sv/pes_back.sv =====
module pes_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pes_pkg::cls_word_t q_word,
  input  logic               q_empty,
  output logic               q_pop,
  output pes_pkg::out_word_t out_word,
  output logic               out_empty,
  input  logic               out_pop
);
  import pes_pkg::*;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  cls_word_t  cur_r, cur_nxt;
  out_word_t  out_r, out_nxt;
  logic       valid_r, valid_nxt;
  logic       can_load;

  assign can_load  = !valid_r || out_pop;
  assign out_word  = out_r;
  assign out_empty = !valid_r;

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    out_nxt   = out_r;
    valid_nxt = valid_r;
    q_pop     = 1'b0;
    if (can_load) begin
      unique case (phase_r)
        PH_HIGH: begin
          out_nxt.out_byte = hex_digit(cur_r.data[7:4]);
          out_nxt.out_last = 1'b0;
          valid_nxt        = 1'b1;
          phase_nxt        = PH_LOW;
        end
        PH_LOW: begin
          out_nxt.out_byte = hex_digit(cur_r.data[3:0]);
          out_nxt.out_last = cur_r.last;
          valid_nxt        = 1'b1;
          phase_nxt        = PH_NONE;
        end
        default: begin
          if (!q_empty) begin
            q_pop     = 1'b1;
            valid_nxt = 1'b1;
            cur_nxt   = q_word;
            if (q_word.esc) begin
              out_nxt.out_byte = CHAR_PCT;
              out_nxt.out_last = 1'b0;
              phase_nxt        = PH_HIGH;
            end else begin
              out_nxt.out_byte = q_word.data;
              out_nxt.out_last = q_word.last;
            end
          end else begin
            valid_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NONE;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

endmodule

// ===== sv/percent_encode_stream_core.sv =====
// A pushed word goes into the queue, then into the back end's output register.
// Throughput: one input word per cycle while the queue has room; the result side
// emits one word per cycle while it is popped, and an escaped byte becomes three words.
// The front queue (QUEUE_DEPTH words) absorbs bursts of escaped bytes.
// Reset is synchronous and active low; it empties the queue and sets the mode to generic.
module percent_encode_stream_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  logic               in_push,
  input  pes_pkg::in_word_t  in_word,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output pes_pkg::out_word_t out_word
);
  import pes_pkg::*;

  logic      q_push, q_pop, q_empty;
  cls_word_t q_wr_word, q_rd_word;

  pes_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_word  (in_word),
    .q_push   (q_push),
    .q_word   (q_wr_word)
  );

  pes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_wr_word),
    .full      (in_full),
    .pop       (q_pop),
    .pop_word  (q_rd_word),
    .empty     (q_empty)
  );

  pes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_word    (q_rd_word),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_word  (out_word),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

// ===== tb/tb_percent_encode_stream_core.sv =====
module tb_percent_encode_stream_core;
  import pes_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_data = MODE_GENERIC;
  logic in_push = 1'b0;
  in_word_t in_word = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_word_t out_word;

  in_word_t pending_q [$];
  out_word_t escaped_q [$];
  logic [1:0] mode_shadow = MODE_GENERIC;
  logic in_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  percent_encode_stream_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'("0") + 8'(nib);
    end
    return 8'("a") + 8'(nib) - 8'd10;
  endfunction

  function automatic logic byte_unreserved(input logic [7:0] b, input logic [1:0] mode);
    if (b <= 8'd32 || b >= 8'd127) begin
      return 1'b0;
    end
    if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) begin
      return 1'b1;
    end
    if (b == "-" || b == "." || b == "_" || b == "~") begin
      return 1'b1;
    end
    if ((mode == MODE_PATH || mode == MODE_QUERY) && b == "/") begin
      return 1'b1;
    end
    return mode == MODE_QUERY && b == "=";
  endfunction

  function automatic void predict_escape(input in_word_t w, input logic [1:0] mode);
    if (byte_unreserved(w.in_byte, mode)) begin
      escaped_q.push_back('{out_byte: w.in_byte, out_last: w.in_last});
    end else if (mode == MODE_QUERY && w.in_byte == CHAR_SPACE) begin
      escaped_q.push_back('{out_byte: CHAR_PLUS, out_last: w.in_last});
    end else begin
      escaped_q.push_back('{out_byte: CHAR_PCT, out_last: 1'b0});
      escaped_q.push_back('{out_byte: nibble_char(w.in_byte[7:4]), out_last: 1'b0});
      escaped_q.push_back('{out_byte: nibble_char(w.in_byte[3:0]), out_last: w.in_last});
    end
  endfunction

  function automatic void note_mismatch(input string what, input out_word_t exp_w,
                                        input out_word_t got_w);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch (%s): expected byte %h last %b, got byte %h last %b",
               what, exp_w.out_byte, exp_w.out_last, got_w.out_byte, got_w.out_last);
    end
  endfunction

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      mode_shadow = MODE_GENERIC;
      in_taken = 1'b0;
    end else begin
      if (cfg_we) begin
        mode_shadow = cfg_data;
      end
      in_taken = in_push && !in_full;
      if (in_taken) begin
        predict_escape(in_word, mode_shadow);
      end
      if (out_pop && !out_empty) begin
        if (escaped_q.size() == 0) begin
          note_mismatch("unexpected word", '0, out_word);
        end else begin
          exp_w = escaped_q.pop_front();
          if (out_word.out_byte !== exp_w.out_byte) begin
            note_mismatch("out_byte", exp_w, out_word);
          end
          if (out_word.out_last !== exp_w.out_last) begin
            note_mismatch("out_last", exp_w, out_word);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!in_push || in_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_word <= pending_q.pop_front();
        in_push <= 1'b1;
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= rst_n && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic queue_word(input logic [7:0] b, input logic last);
    pending_q.push_back('{in_byte: b, in_last: last});
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0, 1, 2: return 8'($urandom_range(255));
      3, 4: begin
        case ($urandom_range(9))
          0: return CHAR_SPACE;
          1: return "/";
          2: return "=";
          3: return "-";
          4: return ".";
          5: return "_";
          6: return "~";
          7: return 8'h00;
          8: return 8'h7f;
          default: return 8'hff;
        endcase
      end
      default: begin
        case ($urandom_range(2))
          0: return 8'($urandom_range(8'h39, 8'h30));
          1: return 8'($urandom_range(8'h5a, 8'h41));
          default: return 8'($urandom_range(8'h7a, 8'h61));
        endcase
      end
    endcase
  endfunction

  task automatic queue_strings(input int n_words);
    int queued;
    int len;
    queued = 0;
    while (queued < n_words) begin
      if ($urandom_range(9) == 0) begin
        queue_word(pick_byte(), 1'($urandom_range(1)));
        queued++;
      end else begin
        len = $urandom_range(8, 1);
        for (int i = 0; i < len && queued < n_words; i++) begin
          queue_word(pick_byte(), i == len - 1);
          queued++;
        end
      end
    end
  endtask

  task automatic write_mode(input logic [1:0] mode);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_push || escaped_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [1:0] mode, input int idle_pct, input int stall_pct,
                           input int n_words, input logic hold);
    write_mode(mode);
    @(posedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queue_strings(n_words);
    if (hold) begin
      hold_left = HOLD_CYCLES;
    end
    drain();
  endtask

  initial begin
    logic [7:0] probes [$];
    probes = '{8'h00, 8'hff, 8'h20, 8'h21, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h39, 8'h3d,
               8'h40, 8'h41, 8'h5a, 8'h5b, 8'h5f, 8'h60, 8'h61, 8'h7a, 8'h7e, 8'h7f,
               8'h80, 8'h25, 8'h2b};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_mode(MODE_GENERIC);
    @(posedge clk);
    foreach (probes[i]) begin
      queue_word(probes[i], i % 5 == 4 || i == probes.size() - 1);
    end
    drain();

    run_phase(MODE_PATH, 0, 0, 18, 1'b0);
    run_phase(MODE_QUERY, 54, 0, 18, 1'b0);
    run_phase(MODE_SPARE, 0, 54, 18, 1'b0);
    run_phase(MODE_GENERIC, 27, 27, 18, 1'b0);
    run_phase(MODE_QUERY, 0, 0, 16, 1'b1);

    repeat (10) @(negedge clk);
    mismatch_cnt += escaped_q.size();
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pes_pkg.sv
sv/pes_front.sv
sv/pes_queue.sv
sv/pes_back.sv
sv/percent_encode_stream_core.sv
tb/tb_percent_encode_stream_core.sv
